// File: hw/rtl/cp1251_to_utf8_transcoder_macros.svh
// Assertion helpers for the transcoder
`ifndef CP1251_TO_UTF8_TRANSCODER_MACROS_SVH
`define CP1251_TO_UTF8_TRANSCODER_MACROS_SVH

// same-cycle implication, quiet during reset
`define C2U_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define C2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/c2u_pkg.sv
package c2u_pkg;

    localparam logic [7:0]  UNDEF_BYTE   = 8'h98;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [6:0]  REPL_RESET   = 7'd63;

    // index of the final byte of a sequence
    localparam logic [1:0]  LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0]  LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0]  LAST_IDX_THREE = 2'd2;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] last_idx;
    } enc_t;

    // code points for bytes 0x80..0xFF
    localparam logic [15:0] UPPER_MAP [128] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
        16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
        16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
        16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
        16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
    };

endpackage

// File: hw/rtl/c2u_ifs.sv
interface c2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink   (input valid, input source_byte, output ready);
endinterface

interface c2u_utf8_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte;
    logic       last_of_char;

    modport source (output valid, output utf8_byte, output last_of_char, input ready);
    modport sink   (input valid, input utf8_byte, input last_of_char, output ready);
endinterface

// File: hw/rtl/cp1251_to_utf8_transcoder.sv
// channel     dir  fields                          notes
// cp_chan     in   source_byte[7:0]                one cp1251 byte per beat
// utf8_chan   out  utf8_byte[7:0], last_of_char    1-3 beats per input byte
// cfg         in   cfg_wr_en, cfg_wr_data[6:0]     replacement for byte 0x98
//
// Each byte goes through the input register, then the result register, to output.
// One output beat per cycle while the output is ready: ASCII and 0x98 give
// 1 beat, Cyrillic 2, the 0x2xxx punctuation 3; the single-byte output port
// sets the rate. Input is taken when the input register is empty or unloads.
// Reset empties both stages and sets the replacement character to 0x3F.
// Output stalls back up through the result register to the input register.
module cp1251_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    c2u_byte_if.sink    cp_chan,
    c2u_utf8_if.source  utf8_chan
);

    logic [6:0]     repl_reg;
    logic           enc_valid;
    logic           enc_ready;
    c2u_pkg::enc_t  enc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= c2u_pkg::REPL_RESET;
        end
        else if (cfg_wr_en)
        begin
            repl_reg <= cfg_wr_data;
        end
    end

    c2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .repl_char (repl_reg),
        .cp_chan   (cp_chan),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc       (enc)
    );

    c2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc       (enc),
        .utf8_chan (utf8_chan)
    );

endmodule

// File: hw/rtl/c2u_front.sv
module c2u_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [6:0]        repl_char,
    c2u_byte_if.sink          cp_chan,
    output logic              enc_valid,
    input  logic              enc_ready,
    output c2u_pkg::enc_t     enc
);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic        take;
    logic [15:0] cp;

    assign cp_chan.ready = !valid_reg || enc_ready;
    assign take          = cp_chan.valid && cp_chan.ready;
    assign enc_valid     = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (enc_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= cp_chan.source_byte;
        end
    end

    assign cp = c2u_pkg::UPPER_MAP[byte_reg[6:0]];

    always_comb
    begin
        enc = '0;
        if (!byte_reg[7])
        begin
            enc.byte0    = byte_reg;
            enc.last_idx = c2u_pkg::LAST_IDX_ONE;
        end
        else if (byte_reg == c2u_pkg::UNDEF_BYTE)
        begin
            enc.byte0    = {1'b0, repl_char};
            enc.last_idx = c2u_pkg::LAST_IDX_ONE;
        end
        else if (cp <= c2u_pkg::TWO_BYTE_MAX)
        begin
            enc.byte0    = c2u_pkg::LEAD_TWO | {3'b000, cp[10:6]};
            enc.byte1    = c2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
            enc.last_idx = c2u_pkg::LAST_IDX_TWO;
        end
        else
        begin
            enc.byte0    = c2u_pkg::LEAD_THREE | {4'b0000, cp[15:12]};
            enc.byte1    = c2u_pkg::CONT_MARK | {2'b00, cp[11:6]};
            enc.byte2    = c2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
            enc.last_idx = c2u_pkg::LAST_IDX_THREE;
        end
    end

endmodule

// File: hw/rtl/c2u_back.sv
`include "cp1251_to_utf8_transcoder_macros.svh"

module c2u_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enc_valid,
    output logic              enc_ready,
    input  c2u_pkg::enc_t     enc,
    c2u_utf8_if.source        utf8_chan
);

    logic           valid_reg;
    logic           valid_next;
    logic [1:0]     idx_reg;
    logic [1:0]     idx_next;
    c2u_pkg::enc_t  data_reg;
    logic           is_last;
    logic           beat;
    logic           load;

    assign is_last   = idx_reg == data_reg.last_idx;
    assign beat      = utf8_chan.valid && utf8_chan.ready;
    assign enc_ready = !valid_reg || (utf8_chan.ready && is_last);
    assign load      = enc_valid && enc_ready;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (beat)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= enc;
        end
    end

    assign utf8_chan.valid        = valid_reg;
    assign utf8_chan.last_of_char = is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    utf8_chan.utf8_byte = data_reg.byte0;
            2'd1:    utf8_chan.utf8_byte = data_reg.byte1;
            2'd2:    utf8_chan.utf8_byte = data_reg.byte2;
            default: utf8_chan.utf8_byte = data_reg.byte0;
        endcase
    end

    `C2U_ASSERT_NOW(a_idx_in_range, clk, rst_n, valid_reg, idx_reg <= data_reg.last_idx, "byte index past end of sequence")
    `C2U_ASSERT_NEXT(a_idx_advance, clk, rst_n, beat && !is_last, valid_reg && (idx_reg == $past(idx_reg) + 2'd1), "sequence did not advance after a beat")
    `C2U_ASSERT_NOW(a_three_lead, clk, rst_n, valid_reg && data_reg.last_idx == c2u_pkg::LAST_IDX_THREE, data_reg.byte0[7:4] == 4'hE, "three-byte sequence without its lead byte")
    `C2U_ASSERT_NOW(a_load_free, clk, rst_n, load && valid_reg, beat && is_last, "new sequence loaded over an unfinished one")

endmodule

// File: tb/tb_cp1251_to_utf8_transcoder.sv
`timescale 1ns / 100ps

module tb_cp1251_to_utf8_transcoder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES = 160;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } utf8_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;

    c2u_byte_if byte_bus ();
    c2u_utf8_if utf8_bus ();

    cp1251_to_utf8_transcoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cp_chan     (byte_bus),
        .utf8_chan   (utf8_bus)
    );

    // published Windows-1251 upper half, 0x80..0xFF
    logic [15:0] w1251_high_cp [0:127] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
        16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
        16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
        16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
        16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
    };

    utf8_beat_t utf8_expected_q [$];
    logic [6:0] repl_model = c2u_pkg::REPL_RESET;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_ticket  = 0;

    int cycle_count    = 0;
    int bytes_sent     = 0;
    int beats_checked  = 0;
    int mismatch_count = 0;
    int repl_writes    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void push_utf8_encoding(input logic [7:0] src);
        logic [15:0] cp;
        cp = w1251_high_cp[src[6:0]];
        if (!src[7])
        begin
            utf8_expected_q.push_back('{value: src, last: 1'b1});
        end
        else if (src == c2u_pkg::UNDEF_BYTE)
        begin
            utf8_expected_q.push_back('{value: {1'b0, repl_model}, last: 1'b1});
        end
        else if (cp <= 16'h07FF)
        begin
            utf8_expected_q.push_back('{value: 8'hC0 | 8'(cp >> 6), last: 1'b0});
            utf8_expected_q.push_back('{value: 8'h80 | {2'b00, cp[5:0]}, last: 1'b1});
        end
        else
        begin
            utf8_expected_q.push_back('{value: 8'hE0 | 8'(cp >> 12), last: 1'b0});
            utf8_expected_q.push_back('{value: 8'h80 | {2'b00, cp[11:6]}, last: 1'b0});
            utf8_expected_q.push_back('{value: 8'h80 | {2'b00, cp[5:0]}, last: 1'b1});
        end
    endfunction

    // valid stays high between back-to-back beats; it only drops while idling
    task automatic send_byte(input logic [7:0] src);
        while (src_idle_en && $urandom_range(99) < 31)
        begin
            byte_bus.valid <= 1'b0;
            @(posedge clk);
        end
        byte_bus.valid       <= 1'b1;
        byte_bus.source_byte <= src;
        do
            @(posedge clk);
        while (!byte_bus.ready);
        push_utf8_encoding(src);
        bytes_sent++;
    endtask

    task automatic wait_all_beats();
        byte_bus.valid <= 1'b0;
        while (utf8_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(input logic [6:0] value);
        wait_all_beats();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        repl_model = value;
        repl_writes++;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_default();
        send_byte(c2u_pkg::UNDEF_BYTE);
        send_byte(8'h3F);
        send_byte(c2u_pkg::UNDEF_BYTE);
    endtask

    task automatic test_directed_bytes();
        logic [7:0] dir_bytes [$];
        dir_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h82, 8'h88, 8'hA0, 8'hA5, 8'hB4,
                      8'hBA, 8'hBC, 8'hBF, 8'hB9, 8'h99, 8'hC0, 8'hA8, 8'h55, 8'hAA,
                      8'h01, 8'h97};
        foreach (dir_bytes[k])
            send_byte(dir_bytes[k]);
    endtask

    task automatic test_replacement_setting();
        write_repl(7'd0);
        send_byte(c2u_pkg::UNDEF_BYTE);
        send_byte(8'h41);
        send_byte(c2u_pkg::UNDEF_BYTE);
        write_repl(7'd127);
        send_byte(c2u_pkg::UNDEF_BYTE);
        send_byte(8'hC8);
        write_repl(7'($urandom_range(1, 126)));
        send_byte(c2u_pkg::UNDEF_BYTE);
        send_byte(8'h85);
    endtask

    // receiver holds off while the sender keeps pushing bytes 0x80..0x9F, multi-byte characters apart from 0x98
    task automatic test_output_hold();
        wait_all_beats();
        src_idle_en = 1'b0;
        hold_ticket <= hold_ticket + 1;
        for (int k = 0; k < 12; k++)
            send_byte(8'h80 | 8'($urandom_range(0, 31)));
        wait_all_beats();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_stream();
        logic [7:0] src;
        int pick;
        for (int n = 0; n < RANDOM_BYTES; n++)
        begin
            if (n == 60)
            begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            if (n == 110)
            begin
                src_idle_en  = 1'b1;
                sink_idle_en = 1'b1;
            end
            if (n == 125 || n == 145)
                write_repl(7'($urandom));
            pick = $urandom_range(99);
            if (pick < 30)
                src = 8'($urandom_range(0, 127));
            else if (pick < 40)
                src = c2u_pkg::UNDEF_BYTE;
            else if (pick < 80)
                src = 8'($urandom_range(128, 255));
            else
                src = 8'($urandom);
            send_byte(src);
        end
        wait_all_beats();
    endtask

    // output ready: random idling plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        utf8_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                utf8_bus.ready <= 1'b0;
            end
            else
            begin
                utf8_bus.ready <= !(sink_idle_en && $urandom_range(99) < 31);
            end
        end
    end

    always @(posedge clk)
    begin
        utf8_beat_t exp_beat;
        if (rst_n && utf8_bus.valid && utf8_bus.ready)
        begin
            beats_checked++;
            if (utf8_expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: byte %02h last %0b",
                             utf8_bus.utf8_byte, utf8_bus.last_of_char);
            end
            else
            begin
                exp_beat = utf8_expected_q.pop_front();
                if (utf8_bus.utf8_byte !== exp_beat.value ||
                    utf8_bus.last_of_char !== exp_beat.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 exp_beat.value, exp_beat.last,
                                 utf8_bus.utf8_byte, utf8_bus.last_of_char);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, utf8_expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        byte_bus.valid       <= 1'b0;
        byte_bus.source_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default();
        test_directed_bytes();
        test_replacement_setting();
        test_output_hold();
        test_random_stream();
        write_repl(c2u_pkg::REPL_RESET);
        send_byte(c2u_pkg::UNDEF_BYTE);
        wait_all_beats();

        if (utf8_expected_q.size() != 0)
        begin
            $display("%0d expected beats never arrived", utf8_expected_q.size());
            mismatch_count += utf8_expected_q.size();
        end
        $display("Covered: %0d cp1251 bytes in, %0d UTF-8 beats checked, %0d mismatches",
                 bytes_sent, beats_checked, mismatch_count);
        $display("Replacement register written %0d times, extremes 0 and 127 included",
                 repl_writes);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
